/* hw/rtl/bucketed_hash_set_engine_defines.svh */
// Assertion macros for the bucketed hash set engine.
// Used by the top level only; depends on nothing else.
`ifndef BUCKETED_HASH_SET_ENGINE_DEFINES_SVH
`define BUCKETED_HASH_SET_ENGINE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define BHSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BHSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/bhse_pkg.sv */
// Shared types and constants of the bucketed hash set engine.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package bhse_pkg;

   localparam int HASH_W = 64;
   localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
   localparam int STATUS_W = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND     = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_INSERTED  = 3'd2,
      ST_PRESENT   = 3'd3,
      ST_FULL      = 3'd4,
      ST_TOO_LONG  = 3'd5,
      ST_EMPTY     = 3'd6
   } status_type;

   typedef struct packed {
      logic start;
   } mod_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_stat_type;

endpackage

/* hw/rtl/bucketed_hash_set_engine.sv */
// Top level of the bucketed hash set engine: byte intake, hash, slot scan sequencer.
// Depends on bhse_pkg, bhse_mod_unit, bhse_slot_store and the assertion macro header.
//
//   Channel  Direction  Handshake          Carries
//   req      in         req_valid/ready    operation, key_byte, last_byte
//   rsp      out        rsp_valid/ready    status, bucket_index, slot_index
//
// A last key word starts the divide step: folds of the upper hash half until it is zero (a single
// fold when BUCKETS is a power of two), then three remainder steps and the hand-over. If the key
// length is in range, each slot of the bucket is read and compared in turn until a match or the
// last slot; then comes the finishing step.
// After reset the slot memory is cleared one entry a cycle, during which no word is accepted.
// A stalled result holds the finishing step; key words, the last one too, are still accepted
// while a result waits.
`timescale 1ns / 1ps
`include "bucketed_hash_set_engine_defines.svh"

module bucketed_hash_set_engine #(
   parameter int BUCKETS       = 4,
   parameter int SLOTS         = 3,
   parameter int MAX_KEY_BYTES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [7:0]                      req_key_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bhse_pkg::STATUS_W-1:0]   rsp_status,
   output logic [1:0]                      rsp_bucket_index,
   output logic [1:0]                      rsp_slot_index
);
   import bhse_pkg::*;

   localparam int ENTRIES = BUCKETS * SLOTS;
   localparam int AW  = $clog2(ENTRIES);
   localparam int RW  = $clog2(BUCKETS);
   localparam int CW  = $clog2(MAX_KEY_BYTES + 2);
   localparam int KW  = 8 * MAX_KEY_BYTES;
   localparam int IW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BXW = (RW > 2) ? RW : 2;
   localparam int SXW = (SW > 2) ? SW : 2;
   localparam logic [CW-1:0] MAX_C     = CW'(MAX_KEY_BYTES);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
   localparam logic [AW-1:0] SLOTS_A   = AW'(SLOTS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIVIDE,
      S_READ,
      S_COMPARE,
      S_FINISH
   } state_type;

   state_type                      state_ff;
   logic [HASH_W-1:0]              hash_ff, hash_in;
   logic [MAX_KEY_BYTES-1:0][7:0]  key_ff, key_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic                           op_ff;
   logic [RW-1:0]                  bucket_ff;
   logic [AW-1:0]                  base_ff;
   logic [SW-1:0]                  slot_idx_ff;
   logic                           hit_ff;
   logic [SW-1:0]                  hit_slot_ff;
   logic                           free_ff;
   logic [SW-1:0]                  free_slot_ff;
   logic                           rsp_valid_ff;
   logic [STATUS_W-1:0]            rsp_status_ff;
   logic [1:0]                     rsp_bucket_ff;
   logic [1:0]                     rsp_slot_ff;

   mod_ctrl_type                   mod_ctrl;
   mod_stat_type                   mod_stat;
   logic [RW-1:0]                  mod_rem;
   logic                           clearing;
   logic                           rd_en;
   logic [AW-1:0]                  rd_addr;
   logic [CW-1:0]                  rd_len;
   logic [KW-1:0]                  rd_key;
   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;

   logic                           accept;
   logic                           out_free;
   logic                           in_range;
   logic                           insert_go;
   status_type                     status_in;
   logic [SW-1:0]                  slot_in;
   logic [BXW-1:0]                 bucket_x;
   logic [SXW-1:0]                 slot_x;

   assign req_ready = (state_ff == S_IDLE) && !clearing;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign in_range  = (count_ff != '0) && (count_ff <= MAX_C);
   assign insert_go = op_ff && in_range && !hit_ff && free_ff;

   always_comb begin
      hash_in  = hash_ff;
      key_in   = key_ff;
      count_in = count_ff;
      if (req_key_byte != 8'd0) begin
         hash_in = ((hash_ff << 5) + hash_ff) ^ {{(HASH_W-8){1'b0}}, req_key_byte};
         if (count_ff < MAX_C) begin
            key_in[count_ff[IW-1:0]] = req_key_byte;
         end
         if (count_ff <= MAX_C) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      slot_in = '0;
      if (count_ff == '0) begin
         status_in = ST_EMPTY;
      end else if (count_ff > MAX_C) begin
         status_in = ST_TOO_LONG;
      end else if (!op_ff) begin
         status_in = hit_ff ? ST_FOUND : ST_NOT_FOUND;
         slot_in   = hit_ff ? hit_slot_ff : '0;
      end else if (hit_ff) begin
         status_in = ST_PRESENT;
         slot_in   = hit_slot_ff;
      end else if (free_ff) begin
         status_in = ST_INSERTED;
         slot_in   = free_slot_ff;
      end else begin
         status_in = ST_FULL;
      end
      bucket_x = BXW'(bucket_ff);
      slot_x   = SXW'(slot_in);
   end

   assign mod_ctrl.start = accept && req_last_byte;
   assign rd_en          = (state_ff == S_READ);
   assign rd_addr        = base_ff + AW'(slot_idx_ff);
   assign wr_en          = (state_ff == S_FINISH) && out_free && insert_go;
   assign wr_addr        = base_ff + AW'(free_slot_ff);

   bhse_mod_unit #(
      .BUCKETS(BUCKETS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mod_ctrl),
      .dividend  (hash_in),
      .stat      (mod_stat),
      .remainder (mod_rem)
   );

   bhse_slot_store #(
      .BUCKETS       (BUCKETS),
      .SLOTS         (SLOTS),
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_len   (rd_len),
      .rd_key   (rd_key),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_len   (count_ff),
      .wr_key   (key_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hash_ff       <= HASH_SEED;
         key_ff        <= '0;
         count_ff      <= '0;
         op_ff         <= 1'b0;
         bucket_ff     <= '0;
         base_ff       <= '0;
         slot_idx_ff   <= '0;
         hit_ff        <= 1'b0;
         hit_slot_ff   <= '0;
         free_ff       <= 1'b0;
         free_slot_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= '0;
         rsp_bucket_ff <= '0;
         rsp_slot_ff   <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  hash_ff  <= hash_in;
                  key_ff   <= key_in;
                  count_ff <= count_in;
                  op_ff    <= req_operation;
                  if (req_last_byte) begin
                     hit_ff   <= 1'b0;
                     free_ff  <= 1'b0;
                     state_ff <= S_DIVIDE;
                  end
               end
            end
            S_DIVIDE: begin
               if (mod_stat.done) begin
                  bucket_ff   <= mod_rem;
                  base_ff     <= AW'(mod_rem) * SLOTS_A;
                  slot_idx_ff <= '0;
                  state_ff    <= in_range ? S_READ : S_FINISH;
               end
            end
            S_READ: begin
               state_ff <= S_COMPARE;
            end
            S_COMPARE: begin
               if (rd_len == count_ff && rd_key == key_ff) begin
                  hit_ff      <= 1'b1;
                  hit_slot_ff <= slot_idx_ff;
                  state_ff    <= S_FINISH;
               end else begin
                  if (rd_len == '0 && !free_ff) begin
                     free_ff      <= 1'b1;
                     free_slot_ff <= slot_idx_ff;
                  end
                  if (slot_idx_ff == LAST_SLOT) begin
                     state_ff <= S_FINISH;
                  end else begin
                     slot_idx_ff <= slot_idx_ff + 1'b1;
                     state_ff    <= S_READ;
                  end
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_in;
                  rsp_bucket_ff <= bucket_x[1:0];
                  rsp_slot_ff   <= slot_x[1:0];
                  hash_ff       <= HASH_SEED;
                  key_ff        <= '0;
                  count_ff      <= '0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bucket_index = rsp_bucket_ff;
   assign rsp_slot_index   = rsp_slot_ff;

   `BHSE_ASSERT_NEXT(a_last_starts_divide, clock, reset, accept && req_last_byte, state_ff == S_DIVIDE, "last word did not start the remainder unit")
   `BHSE_ASSERT_NOW(a_done_in_divide, clock, reset, mod_stat.done, state_ff == S_DIVIDE, "remainder finished outside the divide step")
   `BHSE_ASSERT_NEXT(a_finish_gives_word, clock, reset, state_ff == S_FINISH && out_free, rsp_valid_ff && state_ff == S_IDLE, "finishing step gave no result word")
   `BHSE_ASSERT_NOW(a_write_only_insert, clock, reset, wr_en, op_ff && !clearing && !mod_stat.busy, "slot written outside an insert")

endmodule

/* hw/rtl/bhse_mod_unit.sv */
// Remainder unit: 64-bit hash modulo the bucket count on one shared multiplier.
// Folds the upper half down, then reciprocal multiplication and one correction; uses bhse_pkg.
`timescale 1ns / 1ps

module bhse_mod_unit #(
   parameter int BUCKETS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bhse_pkg::mod_ctrl_type        ctrl,
   input  logic [bhse_pkg::HASH_W-1:0]   dividend,
   output bhse_pkg::mod_stat_type        stat,
   output logic [$clog2(BUCKETS)-1:0]    remainder
);
   import bhse_pkg::*;

   localparam int RW    = $clog2(BUCKETS);
   localparam int HW    = HASH_W / 2;
   localparam int MW    = HW + 1;
   localparam int PW    = 2 * MW;
   localparam int SHIFT = HW + RW;
   localparam logic [MW-1:0] FOLD_K  = MW'((64'd1 << HW) % 64'(BUCKETS));
   localparam logic [MW-1:0] RECIP   = MW'((64'd1 << SHIFT) / 64'(BUCKETS));
   localparam logic [MW-1:0] DIVISOR = MW'(BUCKETS);
   localparam logic [HW-1:0] DIV_LO  = HW'(BUCKETS);

   typedef enum logic [2:0] {
      P_IDLE,
      P_FOLD,
      P_RECIP,
      P_BACK,
      P_FIX
   } phase_type;

   phase_type          phase_ff;
   logic [HASH_W-1:0]  acc_ff;
   logic [HW-1:0]      quot_ff;
   logic [RW-1:0]      rem_ff;
   logic               done_ff;
   logic [MW-1:0]      mul_a;
   logic [MW-1:0]      mul_b;
   logic [PW-1:0]      prod;
   logic [HASH_W-1:0]  fold_sum;
   logic [HW-1:0]      back_diff;
   logic [HW-1:0]      fix_diff;

   // The upper half is worth FOLD_K times its value in the lower half, modulo the bucket count.
   always_comb begin
      case (phase_ff)
         P_FOLD: begin
            mul_a = MW'(acc_ff[HASH_W-1:HW]);
            mul_b = FOLD_K;
         end
         P_RECIP: begin
            mul_a = MW'(acc_ff[HW-1:0]);
            mul_b = RECIP;
         end
         P_BACK: begin
            mul_a = MW'(quot_ff);
            mul_b = DIVISOR;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod      = PW'(mul_a) * PW'(mul_b);
   assign fold_sum  = prod[HASH_W-1:0] + {{HW{1'b0}}, acc_ff[HW-1:0]};
   assign back_diff = acc_ff[HW-1:0] - prod[HW-1:0];
   assign fix_diff  = acc_ff[HW-1:0] - DIV_LO;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         acc_ff   <= '0;
         quot_ff  <= '0;
         rem_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (phase_ff == P_FIX);
         case (phase_ff)
            P_IDLE: begin
               if (ctrl.start) begin
                  acc_ff   <= dividend;
                  phase_ff <= P_FOLD;
               end
            end
            P_FOLD: begin
               acc_ff <= fold_sum;
               if (fold_sum[HASH_W-1:HW] == '0) begin
                  phase_ff <= P_RECIP;
               end
            end
            P_RECIP: begin
               quot_ff  <= HW'(prod >> SHIFT);
               phase_ff <= P_BACK;
            end
            P_BACK: begin
               acc_ff   <= {{HW{1'b0}}, back_diff};
               phase_ff <= P_FIX;
            end
            P_FIX: begin
               rem_ff   <= (acc_ff[HW-1:0] >= DIV_LO) ? fix_diff[RW-1:0] : acc_ff[RW-1:0];
               phase_ff <= P_IDLE;
            end
            default: begin
               phase_ff <= P_IDLE;
            end
         endcase
      end
   end

   assign stat.busy = (phase_ff != P_IDLE);
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

/* hw/rtl/bhse_slot_store.sv */
// Slot memory: length and key bytes of every slot, one entry per bucket and slot.
// Cleared of lengths by a pass after reset; depends on bhse_pkg.
`timescale 1ns / 1ps

module bhse_slot_store #(
   parameter int BUCKETS       = 4,
   parameter int SLOTS         = 3,
   parameter int MAX_KEY_BYTES = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   output logic                                    clearing,
   input  logic                                    rd_en,
   input  logic [$clog2(BUCKETS*SLOTS)-1:0]        rd_addr,
   output logic [$clog2(MAX_KEY_BYTES+2)-1:0]      rd_len,
   output logic [8*MAX_KEY_BYTES-1:0]              rd_key,
   input  logic                                    wr_en,
   input  logic [$clog2(BUCKETS*SLOTS)-1:0]        wr_addr,
   input  logic [$clog2(MAX_KEY_BYTES+2)-1:0]      wr_len,
   input  logic [8*MAX_KEY_BYTES-1:0]              wr_key
);
   import bhse_pkg::*;

   localparam int ENTRIES = BUCKETS * SLOTS;
   localparam int AW      = $clog2(ENTRIES);
   localparam int CW      = $clog2(MAX_KEY_BYTES + 2);
   localparam int KW      = 8 * MAX_KEY_BYTES;
   localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

   logic [CW+KW-1:0] mem [ENTRIES];
   logic [CW+KW-1:0] rdata_ff;
   logic             clr_ff;
   logic [AW-1:0]    clr_addr_ff;
   logic             we;
   logic [AW-1:0]    waddr;
   logic [CW+KW-1:0] wdata;

   assign we    = clr_ff | wr_en;
   assign waddr = clr_ff ? clr_addr_ff : wr_addr;
   assign wdata = clr_ff ? '0 : {wr_len, wr_key};

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clr_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign clearing = clr_ff;
   assign rd_len   = rdata_ff[CW+KW-1:KW];
   assign rd_key   = rdata_ff[KW-1:0];

endmodule

/* dv/bucketed_hash_set_engine_checker.sv */
// Scoreboard for the bucketed hash set engine: predicts each lookup from the key words
// it sees accepted and compares every result word. Depends on bhse_pkg from the RTL.
`timescale 1ns / 1ps

package bhse_tb_pkg;

   typedef enum logic {
      OP_FIND   = 1'b0,
      OP_INSERT = 1'b1
   } key_op_type;

endpackage

module bucketed_hash_set_engine_checker #(
   parameter int BUCKETS       = 4,
   parameter int SLOTS         = 3,
   parameter int MAX_KEY_BYTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_operation,
   input  logic [7:0]                    req_key_byte,
   input  logic                          req_last_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [bhse_pkg::STATUS_W-1:0] rsp_status,
   input  logic [1:0]                    rsp_bucket_index,
   input  logic [1:0]                    rsp_slot_index,
   output int                            mismatches,
   output int                            outstanding,
   output int                            lookups_checked,
   output logic [6:0]                    statuses_seen
);
   import bhse_pkg::*;
   import bhse_tb_pkg::*;

   typedef struct {
      status_type  status;
      logic [1:0]  bucket;
      logic [1:0]  slot;
   } lookup_outcome_type;

   lookup_outcome_type lookups_due[$];

   logic [HASH_W-1:0] running_hash;
   logic [7:0]        key_bytes [MAX_KEY_BYTES];
   int unsigned       key_len;
   int unsigned       stored_len [BUCKETS][SLOTS];
   logic [7:0]        stored_key [BUCKETS][SLOTS][MAX_KEY_BYTES];

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s mismatch, got %0d, wanted %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic restart_key();
      running_hash = HASH_SEED;
      key_len = 0;
      for (int i = 0; i < MAX_KEY_BYTES; i++) key_bytes[i] = 8'd0;
   endtask

   task automatic digest_word(input logic op, input logic [7:0] b, input logic last);
      lookup_outcome_type outcome;
      int unsigned        bucket;
      int                 hit;
      bit                 same;
      if (b != 8'd0) begin
         running_hash = ((running_hash << 5) + running_hash) ^ {56'd0, b};
         if (key_len < MAX_KEY_BYTES) key_bytes[key_len] = b;
         if (key_len <= MAX_KEY_BYTES) key_len++;
      end
      if (!last) return;
      bucket = int'(running_hash % 64'(BUCKETS));
      outcome.bucket = 2'(bucket);
      outcome.slot = 2'd0;
      if (key_len == 0) begin
         outcome.status = ST_EMPTY;
      end else if (key_len > MAX_KEY_BYTES) begin
         outcome.status = ST_TOO_LONG;
      end else begin
         hit = -1;
         for (int s = 0; s < SLOTS; s++) begin
            if (hit < 0 && stored_len[bucket][s] == key_len) begin
               same = 1'b1;
               for (int i = 0; i < key_len; i++)
                  if (stored_key[bucket][s][i] != key_bytes[i]) same = 1'b0;
               if (same) hit = s;
            end
         end
         if (hit >= 0) begin
            outcome.status = (op == OP_FIND) ? ST_FOUND : ST_PRESENT;
            outcome.slot = 2'(hit);
         end else if (op == OP_FIND) begin
            outcome.status = ST_NOT_FOUND;
         end else begin
            outcome.status = ST_FULL;
            for (int s = 0; s < SLOTS; s++) begin
               if (outcome.status == ST_FULL && stored_len[bucket][s] == 0) begin
                  stored_len[bucket][s] = key_len;
                  for (int i = 0; i < MAX_KEY_BYTES; i++)
                     stored_key[bucket][s][i] = key_bytes[i];
                  outcome.status = ST_INSERTED;
                  outcome.slot = 2'(s);
               end
            end
         end
      end
      lookups_due.push_back(outcome);
      restart_key();
   endtask

   task automatic check_result();
      lookup_outcome_type want;
      if (lookups_due.size() == 0) begin
         flag_mismatch("unrequested result word, status", int'(rsp_status), -1);
         return;
      end
      want = lookups_due.pop_front();
      if (rsp_status != want.status)
         flag_mismatch("status", int'(rsp_status), int'(want.status));
      if (rsp_bucket_index != want.bucket)
         flag_mismatch("bucket_index", int'(rsp_bucket_index), int'(want.bucket));
      if (rsp_slot_index != want.slot)
         flag_mismatch("slot_index", int'(rsp_slot_index), int'(want.slot));
      if (rsp_status < 3'd7) statuses_seen[rsp_status] = 1'b1;
      lookups_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_key();
         for (int b = 0; b < BUCKETS; b++)
            for (int s = 0; s < SLOTS; s++) stored_len[b][s] = 0;
         lookups_due.delete();
         mismatches = 0;
         lookups_checked = 0;
         statuses_seen = 7'd0;
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready)
            digest_word(req_operation, req_key_byte, req_last_byte);
      end
      outstanding = lookups_due.size();
   end

endmodule

/* dv/bucketed_hash_set_engine_tb.sv */
// Top of the bucketed hash set engine testbench: clock, reset, key word stimulus and verdict.
// Depends on bhse_pkg, the RTL top level and bucketed_hash_set_engine_checker.
`timescale 1ns / 1ps

module bucketed_hash_set_engine_tb;
   import bhse_pkg::*;
   import bhse_tb_pkg::*;

   localparam int KEY_WORDS   = 1150;
   localparam int CALM_WORDS  = 950;
   localparam int POOL_KEYS   = 16;
   localparam int HOLD_CYCLES = 400;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_operation;
   logic [7:0]          req_key_byte;
   logic                req_last_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [1:0]          rsp_bucket_index;
   logic [1:0]          rsp_slot_index;

   int         mismatches;
   int         outstanding;
   int         lookups_checked;
   logic [6:0] statuses_seen;

   bit           hold_request;
   bit           calm;
   int           words_sent;
   logic [255:0] pool_key [POOL_KEYS];
   int           pool_len [POOL_KEYS];

   bucketed_hash_set_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_key_byte    (req_key_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_bucket_index(rsp_bucket_index),
      .rsp_slot_index  (rsp_slot_index)
   );

   bucketed_hash_set_engine_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_key_byte    (req_key_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_bucket_index(rsp_bucket_index),
      .rsp_slot_index  (rsp_slot_index),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .lookups_checked (lookups_checked),
      .statuses_seen   (statuses_seen)
   );

   always #6 clock = ~clock;

   task automatic send_word(input logic op, input logic [7:0] b, input logic last);
      req_valid <= 1'b1;
      req_operation <= op;
      req_key_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic send_key(input key_op_type op, input logic [255:0] k, input int len);
      for (int i = 0; i < len; i++)
         send_word((i == len - 1) ? op : 1'($urandom_range(0, 1)), k[8*i +: 8], i == len - 1);
   endtask

   function automatic logic [255:0] random_key(input int len);
      logic [255:0] k;
      k = '0;
      for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
      return k;
   endfunction

   function automatic key_op_type random_op();
      return $urandom_range(0, 1) ? OP_INSERT : OP_FIND;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   // Result side: short random stalls, and one long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d lookups outstanding.", outstanding);
      $display("bucketed_hash_set_engine test failed");
      $finish;
   end

   initial begin
      logic [255:0] k;
      int           len;
      int           p;
      int           pos;
      bit           hold_done;
      bit           drained;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = 1'b0;
      req_key_byte = 8'd0;
      req_last_byte = 1'b0;
      hold_request = 1'b0;
      calm = 1'b0;
      words_sent = 0;
      hold_done = 1'b0;
      drained = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_key(OP_INSERT, 256'h01, 1);
      send_key(OP_INSERT, 256'hFF, 1);
      send_key(OP_FIND, 256'hFF, 1);
      send_key(OP_FIND, 256'h80, 1);
      send_key(OP_INSERT, 256'h01, 1);
      send_key(OP_FIND, 256'h00, 1);
      send_key(OP_INSERT, 256'h00, 1);
      send_key(OP_INSERT, 256'h42_00_41, 3);
      send_key(OP_FIND, 256'h42_41, 2);
      k = '0;
      for (int i = 0; i < 17; i++) k[8*i +: 8] = (i % 2) ? 8'hAA : 8'h55;
      send_key(OP_INSERT, k, 17);

      for (int i = 0; i < POOL_KEYS; i++) begin
         p = $urandom_range(0, 9);
         pool_len[i] = (p < 7) ? $urandom_range(1, 4) : (p < 9) ? $urandom_range(5, 15) : 16;
         pool_key[i] = random_key(pool_len[i]);
      end

      while (words_sent < KEY_WORDS) begin
         calm = words_sent >= CALM_WORDS;
         if (words_sent >= 300 && !hold_done) begin
            hold_request = 1'b1;
            hold_done = 1'b1;
         end
         if (words_sent >= 600 && !drained) begin
            wait_drained();
            drained = 1'b1;
         end
         case ($urandom_range(0, 9))
            7: begin
               len = $urandom_range(1, 6);
               send_key(random_op(), random_key(len), len);
            end
            8: begin
               case ($urandom_range(0, 2))
                  0: send_key(random_op(), '0, $urandom_range(1, 2));
                  1: begin
                     len = $urandom_range(17, 20);
                     send_key(random_op(), random_key(len), len);
                  end
                  default: begin
                     p = $urandom_range(0, POOL_KEYS - 1);
                     pos = $urandom_range(0, pool_len[p]);
                     k = '0;
                     for (int i = 0; i <= pool_len[p]; i++)
                        if (i < pos) k[8*i +: 8] = pool_key[p][8*i +: 8];
                        else if (i > pos) k[8*i +: 8] = pool_key[p][8*(i-1) +: 8];
                     send_key(random_op(), k, pool_len[p] + 1);
                  end
               endcase
            end
            9: send_key(random_op(), random_key(16), 16);
            default: begin
               p = $urandom_range(0, POOL_KEYS - 1);
               send_key(random_op(), pool_key[p], pool_len[p]);
            end
         endcase
      end

      wait_drained();
      repeat (80) @(posedge clock);
      @(negedge clock);
      $display("Sent %0d key words and checked %0d lookup results.", words_sent, lookups_checked);
      $display("Status codes seen, one bit per code from empty down to found: %b.",
               statuses_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("bucketed_hash_set_engine test passed");
      end else begin
         $display("%0d mismatches, %0d lookups unanswered.", mismatches, outstanding);
         $display("bucketed_hash_set_engine test failed");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/bhse_pkg.sv
hw/rtl/bhse_mod_unit.sv
hw/rtl/bhse_slot_store.sv
hw/rtl/bucketed_hash_set_engine.sv
dv/bucketed_hash_set_engine_checker.sv
dv/bucketed_hash_set_engine_tb.sv
